[rtl/bgmd_pkg.sv]
// Package for the bit-group modulo distributor.
// Holds shared constants, register indexes and the controller/datapath interface types.
// No dependencies.
package bgmd_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_BITS_PER_VALUE  = 2'd0;
	localparam logic [1:0] REG_LIMIT_VALUE     = 2'd1;
	localparam logic [1:0] REG_NUM_STREAMS     = 2'd2;
	localparam logic [1:0] REG_SEQUENCE_LENGTH = 2'd3;

	// Register and field widths
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;
	localparam int BPV_W     = 6;
	localparam int LIM_W     = 32;
	localparam int NS_W      = 4;
	localparam int LEN_W     = 17;
	localparam int ACC_W     = 32;
	localparam int STRM_W    = 3;
	localparam int POS_W     = 16;

	// Fixed limits
	localparam int VALUE_WIDTH       = 32;
	localparam int MAX_LENGTH        = 65536;
	localparam int MAX_STREAMS_DEF   = 8;

	// Remainder unit: one quotient bit per cycle over the whole accumulator
	localparam int DIV_STEPS = ACC_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Reset values of the configuration registers
	localparam logic [BPV_W-1:0] BPV_RST = BPV_W'(8);
	localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(256);
	localparam logic [NS_W-1:0]  NS_RST  = NS_W'(1);
	localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(1);

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;    // input item taken this cycle
		logic div_start; // accepted item completes a group: load the remainder unit
		logic div_step;  // advance the remainder unit by one bit
		logic out_load;  // move the finished remainder into the output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic group_done; // the offered item completes a group
	} sts_t;

endpackage

[rtl/bgmd_ctrl.sv]
// Controller for the bit-group modulo distributor.
// Sequences item acceptance, the bit-serial remainder unit and the output handshake.
// Depends on bgmd_pkg.
module bgmd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  bgmd_pkg::sts_t sts,
	output bgmd_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	localparam logic [bgmd_pkg::DIV_CNT_W-1:0] DIV_LAST =
		bgmd_pkg::DIV_CNT_W'(bgmd_pkg::DIV_STEPS - 1);

	logic [1:0]                     state_q;
	logic [1:0]                     state_d;
	logic [bgmd_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic                           out_valid_q;
	logic                           out_free;

	// Output register may take a new result when empty or being emptied
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands and next state
	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && sts.group_done) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state, step count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A loaded result is offered in the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not offered");

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output overwritten while stalled");

	// Remainder unit runs exactly its step count before the hand-off
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == DIV_LAST) |=> state_q == ST_HOLD)
		else $error("remainder unit overran");

	// A completed group always enters the remainder unit
	a_div_enter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ST_DIV && div_cnt_q == '0))
		else $error("group not handed to remainder unit");

endmodule

[rtl/bgmd_dpath.sv]
// Datapath for the bit-group modulo distributor.
// Holds configuration, bit packing, stream/position counters, the remainder unit and output.
// Depends on bgmd_pkg.
module bgmd_dpath #(
	parameter int MAX_STREAMS = bgmd_pkg::MAX_STREAMS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bgmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgmd_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           bit_in,
	input  logic                           start_req,
	input  bgmd_pkg::cmd_t                 cmd,
	output bgmd_pkg::sts_t                 sts,
	output logic [bgmd_pkg::ACC_W-1:0]     value,
	output logic [bgmd_pkg::STRM_W-1:0]    stream_index,
	output logic [bgmd_pkg::POS_W-1:0]     position,
	output logic                           last
);

	localparam int SC_W  = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int NSC_W = ($clog2(MAX_STREAMS + 1) > bgmd_pkg::NS_W) ?
		$clog2(MAX_STREAMS + 1) : bgmd_pkg::NS_W;
	localparam int ACC_W = bgmd_pkg::ACC_W;
	localparam int BPV_W = bgmd_pkg::BPV_W;
	localparam int LEN_W = bgmd_pkg::LEN_W;
	localparam int POS_W = bgmd_pkg::POS_W;

	localparam logic [BPV_W-1:0] BPV_MAX = BPV_W'(bgmd_pkg::VALUE_WIDTH);
	localparam logic [NSC_W-1:0] NS_MAX  = NSC_W'(MAX_STREAMS);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(bgmd_pkg::MAX_LENGTH);

	// Configuration registers
	logic [BPV_W-1:0]               bpv_q;
	logic [bgmd_pkg::LIM_W-1:0]     lim_q;
	logic [bgmd_pkg::NS_W-1:0]      ns_q;
	logic [LEN_W-1:0]               len_q;

	// Run state
	logic [ACC_W-1:0]               acc_q;
	logic [BPV_W-1:0]               bit_cnt_q;
	logic [SC_W-1:0]                strm_cnt_q;
	logic [POS_W-1:0]               pos_cnt_q;
	logic                           run_done_q;

	// Remainder unit and tags of the group in flight
	logic [ACC_W-1:0]               dvd_q;
	logic [ACC_W-1:0]               rem_q;
	logic [bgmd_pkg::STRM_W-1:0]    tag_strm_q;
	logic [POS_W-1:0]               tag_pos_q;
	logic                           tag_last_q;

	// Output register
	logic [ACC_W-1:0]               out_value_q;
	logic [bgmd_pkg::STRM_W-1:0]    out_strm_q;
	logic [POS_W-1:0]               out_pos_q;
	logic                           out_last_q;

	logic [BPV_W-1:0] bpv_eff;
	logic [NSC_W-1:0] ns_eff;
	logic [LEN_W-1:0] len_eff;
	logic [ACC_W-1:0] acc_base;
	logic [ACC_W-1:0] acc_new;
	logic [BPV_W-1:0] bc_base;
	logic [BPV_W-1:0] bc_inc;
	logic [SC_W-1:0]  sc_base;
	logic [POS_W-1:0] pc_base;
	logic             done_base;
	logic             grp_done;
	logic [NSC_W-1:0] sc_inc;
	logic [LEN_W-1:0] pc_inc;
	logic             strm_wrap;
	logic             run_last;
	logic [ACC_W:0]   trial;
	logic [ACC_W:0]   trial_sub;
	logic [ACC_W-1:0] rem_next;

	// Clamp configuration to its working ranges
	always_comb begin
		if (bpv_q == '0) begin
			bpv_eff = BPV_W'(1);
		end else if (bpv_q > BPV_MAX) begin
			bpv_eff = BPV_MAX;
		end else begin
			bpv_eff = bpv_q;
		end
		if (ns_q == '0) begin
			ns_eff = NSC_W'(1);
		end else if (NSC_W'(ns_q) > NS_MAX) begin
			ns_eff = NS_MAX;
		end else begin
			ns_eff = NSC_W'(ns_q);
		end
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_q > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = len_q;
		end
	end

	// Start request clears the run before this bit is taken
	assign acc_base  = start_req ? '0 : acc_q;
	assign bc_base   = start_req ? '0 : bit_cnt_q;
	assign sc_base   = start_req ? '0 : strm_cnt_q;
	assign pc_base   = start_req ? '0 : pos_cnt_q;
	assign done_base = start_req ? 1'b0 : run_done_q;

	// Pack the bit, least significant first
	assign acc_new  = acc_base | (ACC_W'(bit_in) << bc_base[$clog2(ACC_W)-1:0]);
	assign bc_inc   = bc_base + 1'b1;
	assign grp_done = !done_base && (bc_inc >= bpv_eff);

	// Round-robin position of this value and end of run
	assign sc_inc    = NSC_W'(sc_base) + 1'b1;
	assign pc_inc    = LEN_W'(pc_base) + 1'b1;
	assign strm_wrap = (sc_inc >= ns_eff);
	assign run_last  = strm_wrap && (pc_inc >= len_eff);

	assign sts.group_done = grp_done;

	// Restoring remainder step; a zero modulus subtracts zero at every step, passing the value through
	assign trial     = {rem_q, dvd_q[ACC_W-1]};
	assign trial_sub = trial - {1'b0, lim_q};
	assign rem_next  = (trial >= {1'b0, lim_q}) ? trial_sub[ACC_W-1:0] : trial[ACC_W-1:0];

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpv_q <= bgmd_pkg::BPV_RST;
			lim_q <= bgmd_pkg::LIM_RST;
			ns_q <= bgmd_pkg::NS_RST;
			len_q <= bgmd_pkg::LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bgmd_pkg::REG_BITS_PER_VALUE:  bpv_q <= cfg_data[BPV_W-1:0];
				bgmd_pkg::REG_LIMIT_VALUE:     lim_q <= cfg_data[bgmd_pkg::LIM_W-1:0];
				bgmd_pkg::REG_NUM_STREAMS:     ns_q <= cfg_data[bgmd_pkg::NS_W-1:0];
				bgmd_pkg::REG_SEQUENCE_LENGTH: len_q <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Advance run state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			bit_cnt_q <= '0;
			strm_cnt_q <= '0;
			pos_cnt_q <= '0;
			run_done_q <= 1'b0;
		end else if (cmd.accept) begin
			acc_q <= acc_base;
			bit_cnt_q <= bc_base;
			strm_cnt_q <= sc_base;
			pos_cnt_q <= pc_base;
			run_done_q <= done_base;
			if (grp_done) begin
				acc_q <= '0;
				bit_cnt_q <= '0;
				if (run_last) begin
					run_done_q <= 1'b1;
				end else if (strm_wrap) begin
					strm_cnt_q <= '0;
					pos_cnt_q <= pc_inc[POS_W-1:0];
				end else begin
					strm_cnt_q <= sc_inc[SC_W-1:0];
				end
			end else if (!done_base) begin
				acc_q <= acc_new;
				bit_cnt_q <= bc_inc;
			end
		end
	end

	// Load and step the remainder unit, then hand over to the output register
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= acc_new;
			rem_q <= '0;
			tag_strm_q <= bgmd_pkg::STRM_W'(sc_base);
			tag_pos_q <= pc_base;
			tag_last_q <= run_last;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[ACC_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (cmd.out_load) begin
			out_value_q <= rem_q;
			out_strm_q <= tag_strm_q;
			out_pos_q <= tag_pos_q;
			out_last_q <= tag_last_q;
		end
	end

	assign value        = out_value_q;
	assign stream_index = out_strm_q;
	assign position     = out_pos_q;
	assign last         = out_last_q;

	// A finished run ignores bits until a start request
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !start_req && run_done_q) |=>
			(run_done_q && $stable(pos_cnt_q) && $stable(strm_cnt_q)))
		else $error("finished run disturbed");

	// A completed group always leaves the packing state cleared
	a_group_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && grp_done) |=> (acc_q == '0 && bit_cnt_q == '0))
		else $error("packing state not cleared after group");

endmodule

[rtl/bit_group_modulo_distributor_top.sv]
// Bit-group modulo distributor: one stream bit per item in, packed values modulo a limit out.
// An item inside a group is packed into the accumulator; the item that closes a group is
// loaded into the remainder unit, stepped through it, then handed off to the output register.
// Throughput: 1 item per cycle inside a group; input stalls while a closing item is in the
// remainder unit or waits for the output register; once handed off, the next group fills.
// Reset (arst_n, asynchronous, active low) clears run state, output valid and configuration.
module bit_group_modulo_distributor_top #(
	parameter int MAX_STREAMS = bgmd_pkg::MAX_STREAMS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bgmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgmd_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           bit_in,
	input  logic                           start_req,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bgmd_pkg::ACC_W-1:0]     value,
	output logic [bgmd_pkg::STRM_W-1:0]    stream_index,
	output logic [bgmd_pkg::POS_W-1:0]     position,
	output logic                           last
);

	bgmd_pkg::cmd_t cmd;
	bgmd_pkg::sts_t sts;

	// Sequencing
	bgmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Packing, counters, remainder unit and output register
	bgmd_dpath #(
		.MAX_STREAMS (MAX_STREAMS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.bit_in       (bit_in),
		.start_req    (start_req),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.stream_index (stream_index),
		.position     (position),
		.last         (last)
	);

endmodule
